// ----- hdl/cpc_pkg.sv -----
// Package for the combination and permutation counter: widths, microcode format and program.
`timescale 1ns / 1ps

package cpc_pkg;

   // Field widths of one request and one response.
   localparam int NW        = 5;
   localparam int MaxN      = 20;
   localparam int CombW     = 18;
   localparam int CombRepW  = 37;
   localparam int PermW     = 62;
   localparam int PowW      = 64;

   // Datapath widths. Running binomial products stay below 2^41, so the
   // exact divide works on the low 48 bits of the accumulator.
   localparam int AccW      = 64;
   localparam int MulW      = 6;
   localparam int ProdW     = AccW + MulW;
   localparam int DivW      = 48;
   localparam int DivStep   = 8;
   localparam int DivCycles = DivW / DivStep;
   localparam int DcntW     = $clog2(DivCycles);
   localparam int RemW      = NW;
   localparam int PcW       = 4;

   // Accumulator operation of one step.
   typedef enum logic [2:0] {
      ACC_HOLD = 3'd0,
      ACC_ONE  = 3'd1,
      ACC_MUL  = 3'd2,
      ACC_POW  = 3'd3,
      ACC_DIV  = 3'd4
   } acc_op_type;

   // Loads of the binomial base m; loading also selects the pass.
   typedef enum logic [1:0] {
      M_HOLD = 2'd0,
      M_N    = 2'd1,
      M_NR1  = 2'd2
   } m_op_type;

   // Result stores and the final response strobe.
   typedef enum logic [2:0] {
      ST_NONE  = 3'd0,
      ST_BINOM = 3'd1,
      ST_PERM  = 3'd2,
      ST_POW   = 3'd3,
      ST_DONE  = 3'd4
   } st_op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      CND_NEVER    = 3'd0,
      CND_ALWAYS   = 3'd1,
      CND_INVALID  = 3'd2,
      CND_I_EQ_R   = 3'd3,
      CND_DIV_MORE = 3'd4,
      CND_PASS1    = 3'd5,
      CND_REP_NA   = 3'd6,
      CND_POW_END  = 3'd7
   } cond_type;

   typedef struct packed {
      acc_op_type       acc_op;
      m_op_type         m_op;
      st_op_type        st_op;
      cond_type         cond;
      logic [PcW-1:0]   target;
   } ucode_type;

   // Step addresses of the program.
   localparam logic [PcW-1:0] STEP_SETUP_C = 4'd0;
   localparam logic [PcW-1:0] STEP_BTEST   = 4'd1;
   localparam logic [PcW-1:0] STEP_BMUL    = 4'd2;
   localparam logic [PcW-1:0] STEP_BDIV    = 4'd3;
   localparam logic [PcW-1:0] STEP_BNEXT   = 4'd4;
   localparam logic [PcW-1:0] STEP_BEND    = 4'd5;
   localparam logic [PcW-1:0] STEP_SETUP_R = 4'd6;
   localparam logic [PcW-1:0] STEP_RJUMP   = 4'd7;
   localparam logic [PcW-1:0] STEP_PSETUP  = 4'd8;
   localparam logic [PcW-1:0] STEP_PTEST   = 4'd9;
   localparam logic [PcW-1:0] STEP_PMUL    = 4'd10;
   localparam logic [PcW-1:0] STEP_PEND    = 4'd11;
   localparam logic [PcW-1:0] STEP_QTEST   = 4'd12;
   localparam logic [PcW-1:0] STEP_QMUL    = 4'd13;
   localparam logic [PcW-1:0] STEP_QEND    = 4'd14;
   localparam logic [PcW-1:0] STEP_FIN     = 4'd15;

   // Control store: one control word per step.
   function automatic ucode_type ucode(input logic [PcW-1:0] addr);
      ucode_type w;
      w = '{ACC_HOLD, M_HOLD, ST_NONE, CND_NEVER, STEP_SETUP_C};
      unique case (addr)
         STEP_SETUP_C: w = '{ACC_ONE,  M_N,    ST_NONE,  CND_INVALID,  STEP_FIN};
         STEP_BTEST:   w = '{ACC_HOLD, M_HOLD, ST_NONE,  CND_I_EQ_R,   STEP_BEND};
         STEP_BMUL:    w = '{ACC_MUL,  M_HOLD, ST_NONE,  CND_NEVER,    STEP_SETUP_C};
         STEP_BDIV:    w = '{ACC_DIV,  M_HOLD, ST_NONE,  CND_DIV_MORE, STEP_BDIV};
         STEP_BNEXT:   w = '{ACC_HOLD, M_HOLD, ST_NONE,  CND_ALWAYS,   STEP_BTEST};
         STEP_BEND:    w = '{ACC_HOLD, M_HOLD, ST_BINOM, CND_PASS1,    STEP_PSETUP};
         STEP_SETUP_R: w = '{ACC_ONE,  M_NR1,  ST_NONE,  CND_REP_NA,   STEP_PSETUP};
         STEP_RJUMP:   w = '{ACC_HOLD, M_HOLD, ST_NONE,  CND_ALWAYS,   STEP_BTEST};
         STEP_PSETUP:  w = '{ACC_ONE,  M_N,    ST_NONE,  CND_NEVER,    STEP_SETUP_C};
         STEP_PTEST:   w = '{ACC_HOLD, M_HOLD, ST_NONE,  CND_I_EQ_R,   STEP_PEND};
         STEP_PMUL:    w = '{ACC_MUL,  M_HOLD, ST_NONE,  CND_ALWAYS,   STEP_PTEST};
         STEP_PEND:    w = '{ACC_ONE,  M_HOLD, ST_PERM,  CND_NEVER,    STEP_SETUP_C};
         STEP_QTEST:   w = '{ACC_HOLD, M_HOLD, ST_NONE,  CND_POW_END,  STEP_QEND};
         STEP_QMUL:    w = '{ACC_POW,  M_HOLD, ST_NONE,  CND_ALWAYS,   STEP_QTEST};
         STEP_QEND:    w = '{ACC_HOLD, M_HOLD, ST_POW,   CND_NEVER,    STEP_SETUP_C};
         STEP_FIN:     w = '{ACC_HOLD, M_HOLD, ST_DONE,  CND_ALWAYS,   STEP_SETUP_C};
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/combination_permutation_counter.sv -----
// Top level: microcoded sequencer computing C(n,r), C(n+r-1,r), n!/(n-r)! and n^r.
// The power loop ends early once n^r saturates; an invalid request skips every
//   loop and answers with all results at zero.
// Throughput: one request at a time; busy stays high until the response cycle.
//   One shared 64x6 multiplier serves every loop, and an exact divider
//   retires 8 quotient bits per cycle inside the binomial loops.
// Reset: synchronous and active high; clears busy, the strobe and the step counter.
`timescale 1ns / 1ps

module combination_permutation_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cpc_pkg::NW-1:0]          req_n,
   input  logic [cpc_pkg::NW-1:0]          req_r,
   output logic                            rsp_valid,
   output logic [cpc_pkg::CombW-1:0]       rsp_comb,
   output logic [cpc_pkg::CombRepW-1:0]    rsp_comb_rep,
   output logic [cpc_pkg::PermW-1:0]       rsp_perm,
   output logic [cpc_pkg::PowW-1:0]        rsp_perm_rep,
   output logic                            rsp_status,
   output logic                            rsp_rep_not_applicable,
   output logic                            rsp_power_saturated
);
   import cpc_pkg::*;

   // Control registers.
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PcW-1:0]        pc_ff, pc_in;
   logic [NW-1:0]         i_ff, i_in;
   logic [DcntW-1:0]      dcnt_ff, dcnt_in;
   logic                  pass_ff, pass_in;

   // Datapath and result registers.
   logic [NW-1:0]         n_ff, n_in;
   logic [NW-1:0]         r_ff, r_in;
   logic [MulW-1:0]       m_ff, m_in;
   logic [AccW-1:0]       acc_ff, acc_in;
   logic [RemW-1:0]       rem_ff, rem_in;
   logic                  inv_ff, inv_in;
   logic                  rep_na_ff, rep_na_in;
   logic                  sat_ff, sat_in;
   logic [CombW-1:0]      comb_ff, comb_in;
   logic [CombRepW-1:0]   comb_rep_ff, comb_rep_in;
   logic [PermW-1:0]      perm_ff, perm_in;
   logic [PowW-1:0]       perm_rep_ff, perm_rep_in;

   ucode_type             uw;
   logic                  cond_hit;
   logic                  accept;
   logic                  req_bad;
   logic [MulW-1:0]       mult_b;
   logic [ProdW-1:0]      prod;
   logic [AccW-1:0]       div_acc;
   logic [RemW-1:0]       div_rem;

   assign accept = start && !busy_ff;
   assign uw     = ucode(pc_ff);

   // Range and ordering check of a new request.
   assign req_bad = (req_n > NW'(MaxN)) || (req_r > NW'(MaxN)) || (req_r > req_n);

   // Shared multiplier: the binomial and permutation factor m - i, or the base n.
   assign mult_b = (uw.acc_op == ACC_POW) ? {1'b0, n_ff} : (m_ff - {1'b0, i_ff});
   assign prod   = ProdW'(acc_ff) * ProdW'(mult_b);

   // Exact divide by i: eight restoring steps per cycle over the low accumulator bits.
   always_comb begin
      logic [RemW:0]   t;
      logic [RemW-1:0] rem;
      logic [DivStep-1:0] qbits;
      rem   = rem_ff;
      qbits = '0;
      for (int k = 0; k < DivStep; k++) begin
         t = {rem, acc_ff[DivW-1-k]};
         if (t >= {1'b0, i_ff}) begin
            t = t - {1'b0, i_ff};
            qbits[DivStep-1-k] = 1'b1;
         end
         rem = t[RemW-1:0];
      end
      div_rem = rem;
      div_acc = {{(AccW-DivW){1'b0}}, acc_ff[DivW-DivStep-1:0], qbits};
   end

   // Jump condition of the current step.
   always_comb begin
      unique case (uw.cond)
         CND_NEVER:    cond_hit = 1'b0;
         CND_ALWAYS:   cond_hit = 1'b1;
         CND_INVALID:  cond_hit = inv_ff;
         CND_I_EQ_R:   cond_hit = (i_ff == r_ff);
         CND_DIV_MORE: cond_hit = (dcnt_ff != DcntW'(DivCycles - 1));
         CND_PASS1:    cond_hit = pass_ff;
         CND_REP_NA:   cond_hit = rep_na_ff;
         CND_POW_END:  cond_hit = (i_ff == r_ff) || sat_ff;
         default:      cond_hit = 1'b0;
      endcase
   end

   // Sequencer and datapath next state.
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      pc_in        = pc_ff;
      i_in         = i_ff;
      dcnt_in      = dcnt_ff;
      pass_in      = pass_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      inv_in       = inv_ff;
      rep_na_in    = rep_na_ff;
      sat_in       = sat_ff;
      comb_in      = comb_ff;
      comb_rep_in  = comb_rep_ff;
      perm_in      = perm_ff;
      perm_rep_in  = perm_rep_ff;

      if (accept) begin
         // Take the request and clear the results of the previous one.
         busy_in     = 1'b1;
         pc_in       = STEP_SETUP_C;
         n_in        = req_n;
         r_in        = req_r;
         inv_in      = req_bad;
         rep_na_in   = !req_bad && (req_n == '0) && (req_r == '0);
         sat_in      = 1'b0;
         comb_in     = '0;
         comb_rep_in = '0;
         perm_in     = '0;
         perm_rep_in = '0;
      end else if (busy_ff) begin
         // Accumulator operation.
         unique case (uw.acc_op)
            ACC_HOLD: ;
            ACC_ONE: begin
               acc_in = AccW'(1);
               i_in   = '0;
            end
            ACC_MUL: begin
               acc_in  = prod[AccW-1:0];
               i_in    = i_ff + 1'b1;
               rem_in  = '0;
               dcnt_in = '0;
            end
            ACC_POW: begin
               i_in = i_ff + 1'b1;
               if (prod[ProdW-1:AccW] != '0) begin
                  acc_in = '1;
                  sat_in = 1'b1;
               end else begin
                  acc_in = prod[AccW-1:0];
               end
            end
            ACC_DIV: begin
               acc_in  = div_acc;
               rem_in  = div_rem;
               dcnt_in = dcnt_ff + 1'b1;
            end
            default: ;
         endcase

         // Binomial base and pass select.
         unique case (uw.m_op)
            M_HOLD: ;
            M_N: begin
               m_in    = {1'b0, n_ff};
               pass_in = 1'b0;
            end
            M_NR1: begin
               m_in    = {1'b0, n_ff} + {1'b0, r_ff} - 1'b1;
               pass_in = 1'b1;
            end
            default: ;
         endcase

         // Result stores and response.
         unique case (uw.st_op)
            ST_NONE: ;
            ST_BINOM: begin
               if (pass_ff) begin
                  comb_rep_in = acc_ff[CombRepW-1:0];
               end else begin
                  comb_in = acc_ff[CombW-1:0];
               end
            end
            ST_PERM:  perm_in     = acc_ff[PermW-1:0];
            ST_POW:   perm_rep_in = acc_ff[PowW-1:0];
            ST_DONE: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
            end
            default: ;
         endcase

         pc_in = cond_hit ? uw.target : pc_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= STEP_SETUP_C;
         i_ff         <= '0;
         dcnt_ff      <= '0;
         pass_ff      <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         dcnt_ff      <= dcnt_in;
         pass_ff      <= pass_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      r_ff        <= r_in;
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      inv_ff      <= inv_in;
      rep_na_ff   <= rep_na_in;
      sat_ff      <= sat_in;
      comb_ff     <= comb_in;
      comb_rep_ff <= comb_rep_in;
      perm_ff     <= perm_in;
      perm_rep_ff <= perm_rep_in;
   end

   // Outputs.
   assign busy                   = busy_ff;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_comb               = comb_ff;
   assign rsp_comb_rep           = comb_rep_ff;
   assign rsp_perm               = perm_ff;
   assign rsp_perm_rep           = perm_rep_ff;
   assign rsp_status             = inv_ff;
   assign rsp_rep_not_applicable = rep_na_ff;
   assign rsp_power_saturated    = sat_ff;

endmodule

// ----- hdl/cpc_checker.sv -----
// Port-level checker for the combination and permutation counter, with its bind.
`timescale 1ns / 1ps

module cpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [cpc_pkg::CombW-1:0]       rsp_comb,
   input logic [cpc_pkg::CombRepW-1:0]    rsp_comb_rep,
   input logic [cpc_pkg::PermW-1:0]       rsp_perm,
   input logic [cpc_pkg::PowW-1:0]        rsp_perm_rep,
   input logic                            rsp_status,
   input logic                            rsp_rep_not_applicable,
   input logic                            rsp_power_saturated
);

   // A transfer in makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after a transfer in");

   // The response strobe lasts one cycle and comes only once the block is free.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // An invalid request answers with all counts and the other two flags at zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         (rsp_comb == '0) && (rsp_comb_rep == '0) && (rsp_perm == '0) &&
         (rsp_perm_rep == '0) && !rsp_rep_not_applicable && !rsp_power_saturated)
      else $error("invalid response carries nonzero data");

   // A saturated power reads as all ones.
   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_saturated |-> (rsp_perm_rep == '1))
      else $error("saturated power is not all ones");

endmodule

bind combination_permutation_counter cpc_checker u_cpc_checker (.*);
